[rtl/q2e_pkg.sv]
package q2e_pkg;

  localparam int XY_W = 38;
  localparam int S_W = 32;
  localparam int N_W = 61;
  localparam int Q_W = 31;
  localparam int Z_W = 32;
  localparam int SQRT_STAGES = 31;

  localparam logic signed [XY_W-1:0] ONE_Q30 = XY_W'(64'd1 << 30);

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic [Z_W-1:0]         z;
    logic                   zero;
  } cordic_t;

  typedef struct packed {
    logic signed [XY_W-1:0] rs;
    logic signed [XY_W-1:0] rc;
    logic signed [XY_W-1:0] ys;
    logic signed [XY_W-1:0] yc;
    logic signed [S_W-1:0]  s;
  } carry_t;

  function automatic logic [Z_W-1:0] atan_entry(input logic [4:0] i);
    logic [Z_W-1:0] a;
    case (i)
      5'd0:  a = 32'd536870912;
      5'd1:  a = 32'd316933406;
      5'd2:  a = 32'd167458907;
      5'd3:  a = 32'd85004756;
      5'd4:  a = 32'd42667331;
      5'd5:  a = 32'd21354465;
      5'd6:  a = 32'd10679838;
      5'd7:  a = 32'd5340245;
      5'd8:  a = 32'd2670163;
      5'd9:  a = 32'd1335087;
      5'd10: a = 32'd667544;
      5'd11: a = 32'd333772;
      5'd12: a = 32'd166886;
      5'd13: a = 32'd83443;
      5'd14: a = 32'd41722;
      5'd15: a = 32'd20861;
      5'd16: a = 32'd10430;
      5'd17: a = 32'd5215;
      5'd18: a = 32'd2608;
      5'd19: a = 32'd1304;
      5'd20: a = 32'd652;
      5'd21: a = 32'd326;
      5'd22: a = 32'd163;
      5'd23: a = 32'd81;
      5'd24: a = 32'd41;
      5'd25: a = 32'd20;
      5'd26: a = 32'd10;
      5'd27: a = 32'd5;
      5'd28: a = 32'd3;
      5'd29: a = 32'd1;
      5'd30: a = 32'd1;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

endpackage

[rtl/q2e_sqrt_cell.sv]
module q2e_sqrt_cell #(
  parameter int BIT = 0
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic [q2e_pkg::N_W-1:0]     r_in,
  input  logic [q2e_pkg::Q_W-1:0]     q_in,
  output logic [q2e_pkg::N_W-1:0]     r_out,
  output logic [q2e_pkg::Q_W-1:0]     q_out
);

  logic [q2e_pkg::N_W-1:0] r_r, r_nxt;
  logic [q2e_pkg::Q_W-1:0] q_r, q_nxt;
  logic [63:0]             trial;

  always_comb begin
    trial = (64'(q_in) << (BIT + 1)) + (64'd1 << (2 * BIT));
    r_nxt = r_in;
    q_nxt = q_in;
    if (64'(r_in) >= trial) begin
      r_nxt = q2e_pkg::N_W'(64'(r_in) - trial);
      q_nxt = q_in | (q2e_pkg::Q_W'(1) << BIT);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_r <= r_nxt;
      q_r <= q_nxt;
    end
  end

  assign r_out = r_r;
  assign q_out = q_r;

endmodule

[rtl/q2e_cordic_cell.sv]
module q2e_cordic_cell #(
  parameter int STAGE = 0
) (
  input  logic              clk,
  input  logic              en,
  input  q2e_pkg::cordic_t  d_in,
  output q2e_pkg::cordic_t  d_out
);

  q2e_pkg::cordic_t        d_r, d_nxt;
  logic signed [q2e_pkg::XY_W-1:0] dx, dy;
  logic [q2e_pkg::Z_W-1:0] ang;

  always_comb begin
    dx    = d_in.y >>> STAGE;
    dy    = d_in.x >>> STAGE;
    ang   = q2e_pkg::atan_entry(5'(STAGE));
    d_nxt = d_in;
    if (!d_in.zero) begin
      if (!d_in.y[q2e_pkg::XY_W-1]) begin
        d_nxt.x = d_in.x + dx;
        d_nxt.y = d_in.y - dy;
        d_nxt.z = d_in.z + ang;
      end else begin
        d_nxt.x = d_in.x - dx;
        d_nxt.y = d_in.y + dy;
        d_nxt.z = d_in.z - ang;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign d_out = d_r;

endmodule

[rtl/quaternion_to_euler_angles.sv]
// Converts a unit quaternion to ZYX Euler angles (roll, pitch, yaw).
// The input channel takes one quaternion per beat as four signed Q1.15
// fields; the output channel returns one beat of three signed binary
// angles where 32768 stands for pi.
// The datapath is a fixed pipeline: products, sums, a square, a 31-cell
// bit-serial square root chain and a CORDIC chain of CORDIC_STAGES cells.
// One beat can be accepted every cycle while in_ready is high, since each
// cell holds one item and hands it to its neighbor whenever the chain is
// enabled.
// Reset clears all valid flags, including those of the output and skid
// registers; the data registers are left as they are.
// When the receiver stalls, the result in the output register waits and
// the pipeline keeps moving until one more result arrives, which is held
// in a skid register. Only then does in_ready fall and the whole chain
// freeze, so no result is lost and none is repeated.
module quaternion_to_euler_angles #(
  parameter int ANGLE_WIDTH   = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_quat_x,
  input  logic signed [15:0] in_quat_y,
  input  logic signed [15:0] in_quat_z,
  input  logic signed [15:0] in_quat_w,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_roll_angle,
  output logic signed [15:0] out_pitch_angle,
  output logic signed [15:0] out_yaw_angle
);

  localparam int XY_W = q2e_pkg::XY_W;
  localparam int S_W  = q2e_pkg::S_W;
  localparam int N_W  = q2e_pkg::N_W;
  localparam int Q_W  = q2e_pkg::Q_W;
  localparam int Z_W  = q2e_pkg::Z_W;
  localparam int SQS  = q2e_pkg::SQRT_STAGES;
  localparam int NST  = 3 + SQS + 1 + CORDIC_STAGES;
  localparam int SH   = 32 - ANGLE_WIDTH;
  localparam logic [32:0] HALF = (SH > 0) ? (33'd1 << (SH - 1)) : 33'd0;

  logic en;
  logic [NST-1:0] vld_r;
  logic        out_v_r, skid_v_r;

  assign en       = !skid_v_r;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NST-2:0], in_valid};
    end
  end

  logic signed [31:0] wx_r, yz_r, xx_r, yy_r, wy_r, zx_r, wz_r, xy_r, zz_r;

  always_ff @(posedge clk) begin
    if (en) begin
      wx_r <= in_quat_w * in_quat_x;
      yz_r <= in_quat_y * in_quat_z;
      xx_r <= in_quat_x * in_quat_x;
      yy_r <= in_quat_y * in_quat_y;
      wy_r <= in_quat_w * in_quat_y;
      zx_r <= in_quat_z * in_quat_x;
      wz_r <= in_quat_w * in_quat_z;
      xy_r <= in_quat_x * in_quat_y;
      zz_r <= in_quat_z * in_quat_z;
    end
  end

  q2e_pkg::carry_t c2_nxt, c2_r;
  logic signed [XY_W-1:0] s_raw;

  always_comb begin
    c2_nxt.rs = (XY_W'(wx_r) + XY_W'(yz_r)) <<< 1;
    c2_nxt.rc = q2e_pkg::ONE_Q30 - ((XY_W'(xx_r) + XY_W'(yy_r)) <<< 1);
    c2_nxt.ys = (XY_W'(wz_r) + XY_W'(xy_r)) <<< 1;
    c2_nxt.yc = q2e_pkg::ONE_Q30 - ((XY_W'(yy_r) + XY_W'(zz_r)) <<< 1);
    s_raw     = (XY_W'(wy_r) - XY_W'(zx_r)) <<< 1;
    if (s_raw > q2e_pkg::ONE_Q30) begin
      c2_nxt.s = S_W'(q2e_pkg::ONE_Q30);
    end else if (s_raw < -q2e_pkg::ONE_Q30) begin
      c2_nxt.s = S_W'(-q2e_pkg::ONE_Q30);
    end else begin
      c2_nxt.s = S_W'(s_raw);
    end
  end

  q2e_pkg::carry_t c3_r;
  logic [N_W-1:0]  ssq_r;
  logic signed [63:0] sq_full;

  assign sq_full = c2_r.s * c2_r.s;

  always_ff @(posedge clk) begin
    if (en) begin
      c2_r  <= c2_nxt;
      c3_r  <= c2_r;
      ssq_r <= N_W'(sq_full);
    end
  end

  logic [N_W-1:0] r_ch [SQS+1];
  logic [Q_W-1:0] q_ch [SQS+1];
  q2e_pkg::carry_t dl_r [SQS];

  assign r_ch[0] = (N_W'(1) << 60) - ssq_r;
  assign q_ch[0] = '0;

  for (genvar j = 0; j < SQS; j++) begin : g_sqrt
    q2e_sqrt_cell #(.BIT(SQS - 1 - j)) u_cell (
      .clk   (clk),
      .en    (en),
      .r_in  (r_ch[j]),
      .q_in  (q_ch[j]),
      .r_out (r_ch[j+1]),
      .q_out (q_ch[j+1])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dl_r[0] <= c3_r;
      for (int k = 1; k < SQS; k++) begin
        dl_r[k] <= dl_r[k-1];
      end
    end
  end

  function automatic q2e_pkg::cordic_t pre_turn(input logic signed [XY_W-1:0] yv,
                                                input logic signed [XY_W-1:0] xv);
    q2e_pkg::cordic_t d;
    d.x    = xv;
    d.y    = yv;
    d.z    = '0;
    d.zero = (xv == '0) && (yv == '0);
    if (xv[XY_W-1]) begin
      if (!yv[XY_W-1]) begin
        d.x = yv;
        d.y = -xv;
        d.z = Z_W'(32'h4000_0000);
      end else begin
        d.x = -yv;
        d.y = xv;
        d.z = Z_W'(32'hC000_0000);
      end
    end
    return d;
  endfunction

  q2e_pkg::cordic_t ch_roll [CORDIC_STAGES+1];
  q2e_pkg::cordic_t ch_pitch [CORDIC_STAGES+1];
  q2e_pkg::cordic_t ch_yaw [CORDIC_STAGES+1];
  q2e_pkg::cordic_t pre_roll_r, pre_pitch_r, pre_yaw_r;

  always_ff @(posedge clk) begin
    if (en) begin
      pre_roll_r  <= pre_turn(dl_r[SQS-1].rs, dl_r[SQS-1].rc);
      pre_pitch_r <= pre_turn(XY_W'(dl_r[SQS-1].s), XY_W'(q_ch[SQS]));
      pre_yaw_r   <= pre_turn(dl_r[SQS-1].ys, dl_r[SQS-1].yc);
    end
  end

  assign ch_roll[0]  = pre_roll_r;
  assign ch_pitch[0] = pre_pitch_r;
  assign ch_yaw[0]   = pre_yaw_r;

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
    q2e_cordic_cell #(.STAGE(k)) u_roll (
      .clk (clk), .en (en), .d_in (ch_roll[k]), .d_out (ch_roll[k+1])
    );
    q2e_cordic_cell #(.STAGE(k)) u_pitch (
      .clk (clk), .en (en), .d_in (ch_pitch[k]), .d_out (ch_pitch[k+1])
    );
    q2e_cordic_cell #(.STAGE(k)) u_yaw (
      .clk (clk), .en (en), .d_in (ch_yaw[k]), .d_out (ch_yaw[k+1])
    );
  end

  function automatic logic [15:0] angle_round(input logic [Z_W-1:0] a);
    logic [32:0] v;
    v = ({1'b0, a} + HALF) >> SH;
    return v[15:0];
  endfunction

  logic [15:0] res_roll, res_pitch, res_yaw;
  logic        last_v;

  assign res_roll  = angle_round(ch_roll[CORDIC_STAGES].z);
  assign res_pitch = angle_round(ch_pitch[CORDIC_STAGES].z);
  assign res_yaw   = angle_round(ch_yaw[CORDIC_STAGES].z);
  assign last_v    = vld_r[NST-1];

  logic [15:0] out_roll_r, out_pitch_r, out_yaw_r;
  logic [15:0] skid_roll_r, skid_pitch_r, skid_yaw_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || out_ready) begin
      out_v_r  <= skid_v_r || (en && last_v);
      skid_v_r <= 1'b0;
    end else if (en && last_v) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || out_ready) begin
      if (skid_v_r) begin
        out_roll_r  <= skid_roll_r;
        out_pitch_r <= skid_pitch_r;
        out_yaw_r   <= skid_yaw_r;
      end else begin
        out_roll_r  <= res_roll;
        out_pitch_r <= res_pitch;
        out_yaw_r   <= res_yaw;
      end
    end else if (en) begin
      skid_roll_r  <= res_roll;
      skid_pitch_r <= res_pitch;
      skid_yaw_r   <= res_yaw;
    end
  end

  assign out_valid       = out_v_r;
  assign out_roll_angle  = out_roll_r;
  assign out_pitch_angle = out_pitch_r;
  assign out_yaw_angle   = out_yaw_r;

  a_skid_has_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid register full while output register is empty");

  a_skid_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> !in_ready)
    else $error("input accepted while skid register is full");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_v_r && out_ready) |=> !skid_v_r)
    else $error("skid register did not drain after an output beat");

  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (!skid_v_r && out_v_r && !out_ready && last_v) |=> skid_v_r)
    else $error("finished result not captured while output stalled");

endmodule
